[rtl/csw_pkg.sv]
// Shared constants, codes and types of the Chebyshev series window evaluator.
package csw_pkg;

  localparam int TIME_W = 48;
  localparam int COEF_W = 48;
  localparam int CNT_W = 4;
  localparam int NCOEF = 9;
  localparam int MAX_COEFFS = 9;
  localparam int CFG_IDX_W = 2;
  localparam int STATUS_W = 2;

  localparam int T_W = 32;
  localparam int FRAC_T = 30;
  localparam int FRAC_BITS = 32;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int REM_W = TIME_W + 1;
  localparam int PROD_W = 2 * T_W;
  localparam int REC_SH = 2 * FRAC_T - FRAC_T - 1;
  localparam int REC_N = 2 * (NCOEF - 2) + 1;

  localparam int HALF_W = COEF_W / 2;
  localparam int PP_W = HALF_W + T_W;
  localparam int SUM_W = 56;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_T;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_VALID = 2'd2
  } cfg_reg_t;

  typedef logic [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic                    err;
    logic [CNT_W-1:0]        n;
    logic [TIME_W-1:0]       d;
    logic [TIME_W-1:0]       w;
    coef_t [NCOEF-1:0]       coef;
  } front_item_t;

endpackage

[rtl/csw_if.sv]
// Query and result channel interfaces of the series evaluator.
interface csw_query_if;
  logic                              valid;
  logic                              ready;
  logic [csw_pkg::TIME_W-1:0]        query_time;
  logic [csw_pkg::CNT_W-1:0]         coeff_count;
  logic signed [csw_pkg::COEF_W-1:0] coef_0;
  logic signed [csw_pkg::COEF_W-1:0] coef_1;
  logic signed [csw_pkg::COEF_W-1:0] coef_2;
  logic signed [csw_pkg::COEF_W-1:0] coef_3;
  logic signed [csw_pkg::COEF_W-1:0] coef_4;
  logic signed [csw_pkg::COEF_W-1:0] coef_5;
  logic signed [csw_pkg::COEF_W-1:0] coef_6;
  logic signed [csw_pkg::COEF_W-1:0] coef_7;
  logic signed [csw_pkg::COEF_W-1:0] coef_8;

  modport source (output valid, query_time, coeff_count, coef_0, coef_1, coef_2, coef_3,
                  coef_4, coef_5, coef_6, coef_7, coef_8, input ready);
  modport sink (input valid, query_time, coeff_count, coef_0, coef_1, coef_2, coef_3,
                coef_4, coef_5, coef_6, coef_7, coef_8, output ready);
endinterface

interface csw_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [csw_pkg::COEF_W-1:0] series_value;
  logic [csw_pkg::STATUS_W-1:0]      status;

  modport source (output valid, series_value, status, input ready);
  modport sink (input valid, series_value, status, output ready);
endinterface

[rtl/csw_front.sv]
// Front end: window registers, query classification and the input register.
module csw_front (
  input  logic                            clk,
  input  logic                            rst,
  csw_query_if.sink                       query,
  input  logic                            cfg_we,
  input  logic [csw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [csw_pkg::TIME_W-1:0]      cfg_data,
  output logic                            push_valid,
  input  logic                            push_ready,
  output csw_pkg::front_item_t            push_item
);

  logic [csw_pkg::TIME_W-1:0] window_start;
  logic [csw_pkg::TIME_W-1:0] window_end;
  logic                       window_valid;

  csw_pkg::front_item_t cls;
  csw_pkg::front_item_t item;
  logic                 item_vld;
  logic                 in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end <= '0;
      window_valid <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csw_pkg::CFG_START: window_start <= cfg_data;
        csw_pkg::CFG_END:   window_end <= cfg_data;
        csw_pkg::CFG_VALID: window_valid <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_range = window_valid && (query.query_time >= window_start)
               && (query.query_time <= window_end);
    cls.err = !in_range;
    cls.n = (query.coeff_count > csw_pkg::CNT_W'(csw_pkg::MAX_COEFFS))
            ? csw_pkg::CNT_W'(csw_pkg::MAX_COEFFS) : query.coeff_count;
    cls.d = query.query_time - window_start;
    cls.w = window_end - window_start;
    cls.coef[0] = query.coef_0;
    cls.coef[1] = query.coef_1;
    cls.coef[2] = query.coef_2;
    cls.coef[3] = query.coef_3;
    cls.coef[4] = query.coef_4;
    cls.coef[5] = query.coef_5;
    cls.coef[6] = query.coef_6;
    cls.coef[7] = query.coef_7;
    cls.coef[8] = query.coef_8;
  end

  assign query.ready = !item_vld || push_ready;
  assign push_valid = item_vld;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (query.ready) begin
      item_vld <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (query.valid && query.ready) begin
      item <= cls;
    end
  end

endmodule

[rtl/csw_queue.sv]
// Short queue that decouples the front end from the evaluation pipeline.
module csw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  csw_pkg::front_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output csw_pkg::front_item_t pop_item
);

  csw_pkg::front_item_t entries [csw_pkg::QUEUE_DEPTH];
  logic [csw_pkg::QPTR_W-1:0] wr_ptr;
  logic [csw_pkg::QPTR_W-1:0] rd_ptr;
  logic [csw_pkg::QCNT_W-1:0] count;
  logic                       do_push;
  logic                       do_pop;

  assign push_ready = (count != csw_pkg::QCNT_W'(csw_pkg::QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == csw_pkg::QPTR_W'(csw_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + csw_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == csw_pkg::QPTR_W'(csw_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + csw_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + csw_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - csw_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= csw_pkg::QCNT_W'(csw_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");
`endif

endmodule

[rtl/csw_back.sv]
// Evaluation pipeline: x mapping divider, Chebyshev recurrence, terms and sum.
module csw_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  csw_pkg::front_item_t pop_item,
  csw_result_if.source         result
);

  localparam int QN = csw_pkg::Q_W;
  localparam int RN = csw_pkg::REC_N;
  localparam int NC = csw_pkg::NCOEF;
  localparam int TW = csw_pkg::T_W;
  localparam int PW = csw_pkg::PROD_W;
  localparam int SW = csw_pkg::SUM_W;
  localparam int HW = csw_pkg::HALF_W;
  localparam int RW = csw_pkg::PP_W + 1;

  localparam logic signed [PW-1:0] T_HI = (PW'(1) <<< (TW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] T_LO = ~T_HI;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (csw_pkg::REC_SH - 1);
  localparam logic [RW-1:0] TERM_HALF = RW'(1) << (csw_pkg::FRAC_T - 1);
  localparam logic signed [SW-1:0] V_HI = (SW'(1) <<< (csw_pkg::COEF_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] V_LO = ~V_HI;

  typedef struct packed {
    logic                                err;
    logic [csw_pkg::CNT_W-1:0]           n;
    csw_pkg::coef_t [NC-1:0]             coef;
  } item_t;

  typedef struct packed {
    item_t                               it;
    logic [csw_pkg::REM_W-1:0]           rem;
    logic [csw_pkg::TIME_W-1:0]          w;
    logic [QN-1:0]                       q;
  } div_st_t;

  typedef struct packed {
    item_t                               it;
    logic [TW-1:0]                       x;
    logic [NC-1:0][TW-1:0]               tv;
    logic [PW-1:0]                       prod;
  } rec_st_t;

  typedef struct packed {
    logic                                err;
    logic [NC-1:0]                       en;
    logic [NC-1:0]                       neg;
    csw_pkg::coef_t                      c0;
    logic [NC-1:0][csw_pkg::PP_W-1:0]    pa;
    logic [NC-1:0][csw_pkg::PP_W-1:0]    pb;
  } prod_st_t;

  logic                       adv;
  logic [QN-1:0]              div_vld;
  logic [RN-1:0]              rec_vld;
  logic                       p_vld;
  logic                       t_vld;
  logic                       u1_vld;
  logic                       u2_vld;
  logic                       u3_vld;
  logic                       res_vld;

  div_st_t                    ds [QN];
  rec_st_t                    rs [RN];
  prod_st_t                   ps;
  prod_st_t                   ps_next;
  logic                       t_err;
  logic signed [SW-1:0]       terms [NC];
  logic signed [SW-1:0]       terms_next [NC];
  logic                       u1_err;
  logic signed [SW-1:0]       s1 [5];
  logic                       u2_err;
  logic signed [SW-1:0]       s2 [3];
  logic                       u3_err;
  logic signed [SW-1:0]       sum;

  logic [csw_pkg::REM_W-1:0]  d0;
  logic [csw_pkg::REM_W-1:0]  w0;
  logic                       ge0;
  logic [QN:0]                q_inc;
  logic [TW-1:0]              x0;

  logic signed [csw_pkg::COEF_W-1:0] res_value;
  logic signed [csw_pkg::COEF_W-1:0] res_value_next;
  csw_pkg::status_t                  res_status;
  csw_pkg::status_t                  res_status_next;

  assign adv = !res_vld || result.ready;
  assign pop_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld <= '0;
      rec_vld <= '0;
      p_vld <= 1'b0;
      t_vld <= 1'b0;
      u1_vld <= 1'b0;
      u2_vld <= 1'b0;
      u3_vld <= 1'b0;
      res_vld <= 1'b0;
    end else if (adv) begin
      div_vld <= {div_vld[QN-2:0], pop_valid};
      rec_vld <= {rec_vld[RN-2:0], div_vld[QN-1]};
      p_vld <= rec_vld[RN-1];
      t_vld <= p_vld;
      u1_vld <= t_vld;
      u2_vld <= u1_vld;
      u3_vld <= u2_vld;
      res_vld <= u3_vld;
    end
  end

  // Integer quotient bit first; for a time inside the window it is one only when the time sits at the window end.
  assign d0 = {1'b0, pop_item.d};
  assign w0 = {1'b0, pop_item.w};
  assign ge0 = (d0 >= w0);

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].it <= '{err: pop_item.err, n: pop_item.n, coef: pop_item.coef};
      ds[0].rem <= ge0 ? (d0 - w0) : d0;
      ds[0].w <= pop_item.w;
      ds[0].q <= {{(QN - 1){1'b0}}, ge0};
    end
  end

  for (genvar s = 1; s < QN; s++) begin : g_div
    logic [csw_pkg::REM_W-1:0] r2;
    logic [csw_pkg::REM_W-1:0] wx;
    logic                      ge;

    assign r2 = {ds[s-1].rem[csw_pkg::REM_W-2:0], 1'b0};
    assign wx = {1'b0, ds[s-1].w};
    assign ge = (r2 >= wx);

    always_ff @(posedge clk) begin
      if (adv) begin
        ds[s].it <= ds[s-1].it;
        ds[s].w <= ds[s-1].w;
        ds[s].rem <= ge ? (r2 - wx) : r2;
        ds[s].q <= {ds[s-1].q[QN-2:0], ge};
      end
    end
  end

  assign q_inc = {1'b0, ds[QN-1].q} + (QN + 1)'(1);
  assign x0 = (ds[QN-1].w == '0) ? (TW'(0) - csw_pkg::T_ONE)
                                 : (q_inc[TW:1] - csw_pkg::T_ONE);

  always_ff @(posedge clk) begin
    if (adv) begin
      rs[0].it <= ds[QN-1].it;
      rs[0].x <= x0;
      rs[0].tv <= {{((NC - 2) * TW){1'b0}}, x0, csw_pkg::T_ONE};
      rs[0].prod <= '0;
    end
  end

  for (genvar j = 1; j < RN; j++) begin : g_rec
    if (j % 2 == 1) begin : g_mul
      localparam int K = (j + 3) / 2;
      logic signed [TW-1:0] ma;
      logic signed [TW-1:0] mb;
      logic signed [PW-1:0] mp;
      rec_st_t              nx;

      assign ma = rs[j-1].x;
      assign mb = rs[j-1].tv[K-1];
      assign mp = ma * mb;

      always_comb begin
        nx = rs[j-1];
        nx.prod = mp;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rs[j] <= nx;
        end
      end
    end else begin : g_sub
      localparam int K = (j + 2) / 2;
      logic signed [PW-1:0] p;
      logic signed [PW-1:0] rnd;
      logic signed [PW-1:0] tp;
      logic signed [PW-1:0] dif;
      logic [TW-1:0]        tn;
      rec_st_t              nx;

      // Adding half minus one before the floor shift rounds negative ties away from zero.
      assign p = rs[j-1].prod;
      assign rnd = p + (p[PW-1] ? (RND_HALF - PW'(1)) : RND_HALF);
      assign tp = {{(PW - TW){rs[j-1].tv[K-2][TW-1]}}, rs[j-1].tv[K-2]};
      assign dif = (rnd >>> csw_pkg::REC_SH) - tp;

      always_comb begin
        if (dif > T_HI) begin
          tn = T_HI[TW-1:0];
        end else if (dif < T_LO) begin
          tn = T_LO[TW-1:0];
        end else begin
          tn = dif[TW-1:0];
        end
      end

      always_comb begin
        nx = rs[j-1];
        nx.tv[K] = tn;
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rs[j] <= nx;
        end
      end
    end
  end

  always_comb begin
    logic [csw_pkg::COEF_W-1:0] cm;
    logic [TW-1:0]              tm;
    ps_next.err = rs[RN-1].it.err;
    ps_next.c0 = rs[RN-1].it.coef[0];
    ps_next.pa = '0;
    ps_next.pb = '0;
    ps_next.neg = '0;
    for (int k = 0; k < NC; k++) begin
      ps_next.en[k] = (rs[RN-1].it.n > csw_pkg::CNT_W'(k));
    end
    for (int k = 1; k < NC; k++) begin
      cm = rs[RN-1].it.coef[k][csw_pkg::COEF_W-1]
           ? (csw_pkg::COEF_W'(0) - rs[RN-1].it.coef[k]) : rs[RN-1].it.coef[k];
      tm = rs[RN-1].tv[k][TW-1] ? (TW'(0) - rs[RN-1].tv[k]) : rs[RN-1].tv[k];
      ps_next.pa[k] = cm[csw_pkg::COEF_W-1:HW] * tm;
      ps_next.pb[k] = cm[HW-1:0] * tm;
      ps_next.neg[k] = rs[RN-1].it.coef[k][csw_pkg::COEF_W-1] ^ rs[RN-1].tv[k][TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ps <= ps_next;
    end
  end

  always_comb begin
    logic [RW-1:0] r;
    terms_next[0] = ps.en[0] ? SW'(signed'(ps.c0)) : '0;
    for (int k = 1; k < NC; k++) begin
      r = ({1'b0, ps.pa[k]} + (({1'b0, ps.pb[k]} + TERM_HALF) >> HW))
          >> (csw_pkg::FRAC_T - HW);
      if (!ps.en[k]) begin
        terms_next[k] = '0;
      end else if (ps.neg[k]) begin
        terms_next[k] = SW'(0) - SW'(r);
      end else begin
        terms_next[k] = SW'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_err <= ps.err;
      terms <= terms_next;
      u1_err <= t_err;
      s1[0] <= terms[0] + terms[1];
      s1[1] <= terms[2] + terms[3];
      s1[2] <= terms[4] + terms[5];
      s1[3] <= terms[6] + terms[7];
      s1[4] <= terms[8];
      u2_err <= u1_err;
      s2[0] <= s1[0] + s1[1];
      s2[1] <= s1[2] + s1[3];
      s2[2] <= s1[4];
      u3_err <= u2_err;
      sum <= s2[0] + s2[1] + s2[2];
    end
  end

  always_comb begin
    if (u3_err) begin
      res_value_next = '0;
      res_status_next = csw_pkg::ST_RANGE;
    end else if (sum > V_HI) begin
      res_value_next = V_HI[csw_pkg::COEF_W-1:0];
      res_status_next = csw_pkg::ST_SAT;
    end else if (sum < V_LO) begin
      res_value_next = V_LO[csw_pkg::COEF_W-1:0];
      res_status_next = csw_pkg::ST_SAT;
    end else begin
      res_value_next = sum[csw_pkg::COEF_W-1:0];
      res_status_next = csw_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_value <= res_value_next;
      res_status <= res_status_next;
    end
  end

  assign result.valid = res_vld;
  assign result.series_value = res_value;
  assign result.status = res_status;

`ifndef SYNTHESIS
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status == csw_pkg::ST_RANGE)) |-> (result.series_value == '0))
    else $error("out-of-window result carries a nonzero value");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    (div_vld[QN-1] && !ds[QN-1].it.err && (ds[QN-1].w != '0))
      |-> (ds[QN-1].q <= (QN'(1) << csw_pkg::FRAC_BITS)))
    else $error("window quotient above one");

  a_x_bound: assert property (@(posedge clk) disable iff (rst)
    (rec_vld[0] && !rs[0].it.err)
      |-> (($signed(rs[0].x) <= $signed(csw_pkg::T_ONE))
           && ($signed(rs[0].x) >= -$signed(csw_pkg::T_ONE))))
    else $error("mapped x outside [-1, 1]");
`endif

endmodule

[rtl/chebyshev_series_window_eval_top.sv]
// Top level of the Chebyshev series window evaluator.
// Accepts one query per clock cycle when the result side keeps up. A query passes
// from its transfer to its result through the input register, the queue, the
// bit-per-stage divider that maps the time into x, the pipelined Chebyshev
// recurrence (one multiply and one round-and-subtract stage per order), the
// coefficient product registers, the adder tree and the saturating output register.
// A stalled result halts the whole evaluation pipeline; the two-entry queue and the
// input register keep taking queries until they are full.
module chebyshev_series_window_eval_top (
  input  logic                          clk,
  input  logic                          rst,
  csw_query_if.sink                     query,
  csw_result_if.source                  result,
  input  logic                          cfg_we,
  input  logic [csw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csw_pkg::TIME_W-1:0]    cfg_data
);

  logic                 push_valid;
  logic                 push_ready;
  csw_pkg::front_item_t push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  csw_pkg::front_item_t pop_item;

  csw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .query      (query),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  csw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  csw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .result     (result)
  );

endmodule
